// ===== src/bcw_pkg.sv =====
// Shared types and constants for the core lockup watchdog.
`timescale 1ns / 1ps
`default_nettype none
package bcw_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_ENABLE  = 2'd1;
	localparam logic [1:0] REQ_DISABLE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WD_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLING  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPP_COUNT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PANIC     = 8'd3;

	// Field widths
	localparam int REQ_W   = 2;
	localparam int CORE_W  = 3;
	localparam int TIME_W  = 32;
	localparam int FACT_W  = 8;
	localparam int THR_W   = 2 * FACT_W;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	// Per-cycle control of the core table
	typedef struct packed {
		logic tick_we;
		logic saved_we;
		logic touch_we;
		logic rd_at_scan;
	} bcw_tbl_ctrl_t;

endpackage
`default_nettype wire

// ===== src/bcw_serial_rem.sv =====
// Bit-serial remainder of a tick count by the opportunity count.
`timescale 1ns / 1ps
`default_nettype none
module bcw_serial_rem #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [COUNT_BITS-1:0]         dividend,
	input  wire logic [bcw_pkg::FACT_W-1:0]    divisor,
	output logic                               done,
	output logic                               rem_zero
);
	import bcw_pkg::*;

	localparam int CNT_W = $clog2(COUNT_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [COUNT_BITS-1:0] shreg_q;
	logic [FACT_W-1:0]     rem_q;
	logic [FACT_W:0]       trial;
	logic [FACT_W-1:0]     rem_next;

	// shift in one dividend bit, subtract when the partial remainder reaches the divisor
	always_comb begin
		trial = {rem_q, shreg_q[COUNT_BITS-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = FACT_W'(trial - {1'b0, divisor});
		end else begin
			rem_next = trial[FACT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			shreg_q <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= CNT_W'(COUNT_BITS - 1);
				shreg_q <= dividend;
				rem_q   <= '0;
			end else if (busy_q) begin
				rem_q   <= rem_next;
				shreg_q <= {shreg_q[COUNT_BITS-2:0], 1'b0};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ===== src/bcw_core_table.sv =====
// Per-core tick count, saved count and touch time stores with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module bcw_core_table #(
	parameter int NUM_CORES  = 8,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bcw_pkg::bcw_tbl_ctrl_t         ctrl,
	input  wire logic [$clog2(NUM_CORES)-1:0]   core_idx,
	input  wire logic [$clog2(NUM_CORES)-1:0]   scan_idx,
	input  wire logic [COUNT_BITS-1:0]          tick_wdata,
	input  wire logic [COUNT_BITS-1:0]          saved_wdata,
	input  wire logic [bcw_pkg::TIME_W-1:0]     touch_wdata,
	output logic [COUNT_BITS-1:0]               tick_rdata,
	output logic [COUNT_BITS-1:0]               saved_rdata,
	output logic [bcw_pkg::TIME_W-1:0]          touch_rdata
);
	import bcw_pkg::*;

	localparam int IDX_W = $clog2(NUM_CORES);

	logic [COUNT_BITS-1:0] tick_mem  [NUM_CORES];
	logic [COUNT_BITS-1:0] saved_mem [NUM_CORES];
	logic [TIME_W-1:0]     touch_mem [NUM_CORES];

	logic [NUM_CORES-1:0]  tick_v_q;
	logic [NUM_CORES-1:0]  saved_v_q;
	logic [NUM_CORES-1:0]  touch_v_q;

	logic [COUNT_BITS-1:0] tick_rd_q;
	logic [COUNT_BITS-1:0] saved_rd_q;
	logic [TIME_W-1:0]     touch_rd_q;
	logic                  tick_rv_q;
	logic                  saved_rv_q;
	logic                  touch_rv_q;
	logic [IDX_W-1:0]      tick_raddr;

	assign tick_raddr = ctrl.rd_at_scan ? scan_idx : core_idx;

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_v_q   <= '0;
			saved_v_q  <= '0;
			touch_v_q  <= '0;
			tick_rv_q  <= 1'b0;
			saved_rv_q <= 1'b0;
			touch_rv_q <= 1'b0;
		end else begin
			if (ctrl.tick_we)  tick_v_q[core_idx]  <= 1'b1;
			if (ctrl.saved_we) saved_v_q[scan_idx] <= 1'b1;
			if (ctrl.touch_we) touch_v_q[core_idx] <= 1'b1;
			tick_rv_q  <= tick_v_q[tick_raddr];
			saved_rv_q <= saved_v_q[scan_idx];
			touch_rv_q <= touch_v_q[scan_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tick_we)  tick_mem[core_idx]  <= tick_wdata;
		if (ctrl.saved_we) saved_mem[scan_idx] <= saved_wdata;
		if (ctrl.touch_we) touch_mem[core_idx] <= touch_wdata;
		tick_rd_q  <= tick_mem[tick_raddr];
		saved_rd_q <= saved_mem[scan_idx];
		touch_rd_q <= touch_mem[scan_idx];
	end

	assign tick_rdata  = tick_rv_q  ? tick_rd_q  : '0;
	assign saved_rdata = saved_rv_q ? saved_rd_q : '0;
	assign touch_rdata = touch_rv_q ? touch_rd_q : '0;

endmodule
`default_nettype wire

// ===== src/buddy_core_lockup_watchdog_top.sv =====
// Top level of the multi-core lockup watchdog: sequencer, registers and ports.
`timescale 1ns / 1ps
`default_nettype none
// Each core sends tick, enable and disable requests stamped with a time in
// seconds; every request returns exactly one result byte. A counted tick bumps
// the core's tick count, and when that count is a multiple of the opportunity
// count the next enabled core (wrapping) is checked: it is reported locked when
// its count has not moved since last saved and the signed wrapped gap from its
// touch time reaches the sampling period times the opportunity count. A report
// is raised once until the core recovers. One request is handled at a time and
// s_tready is low meanwhile. A disable or an ignored request goes straight to
// the finish state and an enable first restamps the touch time; s_tready rises
// together with the result. A counted tick reads and bumps its count, waits for
// the bit-serial remainder unit (one count bit per cycle, then a done strobe) and
// then restamps and finishes. A check first scans the cores one at a time (up
// to NUM_CORES - 1 until an enabled neighbor is found, NUM_CORES when there is
// none) and then reads, compares and decides on the neighbor. A finished result
// waits in the output register while s_tready is already high again; a new
// result that finds the register still full holds the block until it is taken.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while the block is idle.
module buddy_core_lockup_watchdog_top #(
	parameter int NUM_CORES  = 8,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request stream; s_tdata: req_type[1:0], core_id[4:2], now_seconds[36:5], zero pad
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [bcw_pkg::S_DATA_W-1:0]      s_tdata,
	// result stream; m_tdata: lockup_found[0], lockup_core[3:1], lockup_panic[4], zero pad
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [bcw_pkg::M_DATA_W-1:0]           m_tdata,
	// register write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bcw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bcw_pkg::*;

	localparam int IDX_W = $clog2(NUM_CORES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CORES - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_RD,
		ST_CNT_INC,
		ST_MOD,
		ST_SCAN,
		ST_NX_RD,
		ST_NX_CHK,
		ST_DECIDE,
		ST_TOUCH,
		ST_FINISH
	} state_t;

	state_t                state_q;

	// configuration
	logic                  wd_en_q;
	logic [FACT_W-1:0]     samp_q;
	logic [FACT_W-1:0]     opp_q;
	logic                  panic_q;

	// per-core flags
	logic [NUM_CORES-1:0]  mask_q;
	logic [NUM_CORES-1:0]  warned_q;

	// request in flight
	logic [IDX_W-1:0]      core_idx_q;
	logic [TIME_W-1:0]     now_q;
	logic [IDX_W-1:0]      scan_idx_q;

	// check operands
	logic [COUNT_BITS-1:0] cnt_nx_q;
	logic                  eq_q;
	logic [TIME_W-1:0]     diff_q;
	logic [THR_W-1:0]      thresh_q;

	// pending result and output register
	logic                  res_found_q;
	logic [CORE_W-1:0]     res_core_q;
	logic                  res_panic_q;
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	// request fields
	logic [REQ_W-1:0]      in_req;
	logic [CORE_W-1:0]     in_core;
	logic [TIME_W-1:0]     in_now;
	logic [IDX_W-1:0]      in_idx;
	logic                  in_range;
	logic                  s_accept;

	logic [FACT_W-1:0]     opp_eff;
	logic                  locked;
	logic [IDX_W-1:0]      scan_first;
	logic [IDX_W-1:0]      scan_next;

	bcw_tbl_ctrl_t         tbl_ctrl;
	logic [COUNT_BITS-1:0] tick_rdata;
	logic [COUNT_BITS-1:0] saved_rdata;
	logic [TIME_W-1:0]     touch_rdata;
	logic [COUNT_BITS-1:0] tick_inc;

	logic                  rem_done;
	logic                  rem_zero;

	assign in_req   = s_tdata[REQ_W-1:0];
	assign in_core  = s_tdata[REQ_W+CORE_W-1:REQ_W];
	assign in_now   = s_tdata[REQ_W+CORE_W+TIME_W-1:REQ_W+CORE_W];
	assign in_idx   = IDX_W'(in_core);
	assign in_range = (32'(in_core) < NUM_CORES);

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// an opportunity count of zero acts as one
	assign opp_eff = (opp_q == '0) ? FACT_W'(1) : opp_q;

	// neighbor scan walks the cores in wrapping order, starting after the ticking core
	assign scan_first = (core_idx_q == LAST_IDX) ? '0 : core_idx_q + 1'b1;
	assign scan_next  = (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + 1'b1;

	// locked: count frozen and a positive wrapped gap at or above the threshold
	assign locked = eq_q && (diff_q != '0) && !diff_q[TIME_W-1] &&
	                (diff_q >= TIME_W'(thresh_q));

	assign tick_inc = tick_rdata + COUNT_BITS'(1);

	always_comb begin
		tbl_ctrl.tick_we    = (state_q == ST_CNT_INC);
		tbl_ctrl.saved_we   = (state_q == ST_DECIDE) && !locked;
		tbl_ctrl.touch_we   = (state_q == ST_TOUCH);
		tbl_ctrl.rd_at_scan = (state_q == ST_NX_RD);
	end

	bcw_core_table #(
		.NUM_CORES  (NUM_CORES),
		.COUNT_BITS (COUNT_BITS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (tbl_ctrl),
		.core_idx    (core_idx_q),
		.scan_idx    (scan_idx_q),
		.tick_wdata  (tick_inc),
		.saved_wdata (cnt_nx_q),
		.touch_wdata (now_q),
		.tick_rdata  (tick_rdata),
		.saved_rdata (saved_rdata),
		.touch_rdata (touch_rdata)
	);

	bcw_serial_rem #(
		.COUNT_BITS (COUNT_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_CNT_INC),
		.dividend (tick_inc),
		.divisor  (opp_eff),
		.done     (rem_done),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wd_en_q     <= 1'b0;
			samp_q      <= FACT_W'(1);
			opp_q       <= FACT_W'(1);
			panic_q     <= 1'b0;
			mask_q      <= '0;
			warned_q    <= '0;
			core_idx_q  <= '0;
			now_q       <= '0;
			scan_idx_q  <= '0;
			cnt_nx_q    <= '0;
			eq_q        <= 1'b0;
			diff_q      <= '0;
			thresh_q    <= '0;
			res_found_q <= 1'b0;
			res_core_q  <= '0;
			res_panic_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// register writes; values are cut to the register width
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WD_ENABLE: wd_en_q <= cfg_data[0];
					REG_SAMPLING:  samp_q  <= cfg_data[FACT_W-1:0];
					REG_OPP_COUNT: opp_q   <= cfg_data[FACT_W-1:0];
					REG_PANIC:     panic_q <= cfg_data[0];
					default: ;
				endcase
			end

			// drop the result once taken, unless ST_FINISH loads the next one
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						core_idx_q  <= in_idx;
						now_q       <= in_now;
						res_found_q <= 1'b0;
						res_core_q  <= '0;
						res_panic_q <= 1'b0;
						if (!in_range) begin
							state_q <= ST_FINISH;
						end else begin
							case (in_req)
								REQ_ENABLE: begin
									mask_q[in_idx] <= 1'b1;
									state_q        <= ST_TOUCH;
								end
								REQ_DISABLE: begin
									mask_q[in_idx] <= 1'b0;
									state_q        <= ST_FINISH;
								end
								REQ_TICK: begin
									if (wd_en_q && mask_q[in_idx]) begin
										state_q <= ST_CNT_RD;
									end else begin
										state_q <= ST_FINISH;
									end
								end
								default: state_q <= ST_FINISH;
							endcase
						end
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_INC;
				end
				ST_CNT_INC: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (rem_done) begin
						scan_idx_q <= scan_first;
						state_q    <= rem_zero ? ST_SCAN : ST_TOUCH;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == core_idx_q) begin
						state_q <= ST_TOUCH;
					end else if (mask_q[scan_idx_q]) begin
						state_q <= ST_NX_RD;
					end else begin
						scan_idx_q <= scan_next;
					end
				end
				ST_NX_RD: begin
					state_q <= ST_NX_CHK;
				end
				ST_NX_CHK: begin
					cnt_nx_q <= tick_rdata;
					eq_q     <= (tick_rdata == saved_rdata);
					diff_q   <= now_q - touch_rdata;
					thresh_q <= THR_W'(samp_q) * THR_W'(opp_eff);
					state_q  <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (locked) begin
						if (!warned_q[scan_idx_q]) begin
							warned_q[scan_idx_q] <= 1'b1;
							res_found_q          <= 1'b1;
							res_core_q           <= CORE_W'(scan_idx_q);
							res_panic_q          <= panic_q;
						end
					end else begin
						warned_q[scan_idx_q] <= 1'b0;
					end
					state_q <= ST_TOUCH;
				end
				ST_TOUCH: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, res_panic_q, res_core_q, res_found_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/bcw_checker.sv =====
// Port-level checker for the lockup watchdog and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bcw_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	input  wire logic                              s_tready,
	input  wire logic [bcw_pkg::S_DATA_W-1:0]      s_tdata,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [bcw_pkg::M_DATA_W-1:0]      m_tdata
);
	import bcw_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// no report means core and severity are zero
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'b0000)
		else $error("core or panic set without a report");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:5] == '0)
		else $error("result padding not zero");

endmodule

bind buddy_core_lockup_watchdog_top bcw_checker u_bcw_checker (.*);
`default_nettype wire

// ===== tb/tb_buddy_core_lockup_watchdog_top.sv =====
// Self-checking testbench for the multi-core lockup watchdog top level.
`timescale 1ns / 1ps
module tb_buddy_core_lockup_watchdog_top;
	import bcw_pkg::*;

	localparam int CORES      = 8;
	localparam int END_CYCLES = 64;
	// request code the block must answer with an empty result
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	// register index that decodes to nothing
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd9;

	// one result byte: lockup_found[0], lockup_core[3:1], lockup_panic[4]
	typedef struct packed {
		logic        panic;
		logic [2:0]  core;
		logic        found;
	} verdict_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register copies kept by the testbench
	logic        wd_on;
	logic [7:0]  samp_s;
	logic [7:0]  opp_n;
	logic        panic_on;
	// per-core watchdog state kept by the testbench
	logic [CORES-1:0] live_mask;
	logic [31:0]      tick_cnt  [CORES];
	logic [31:0]      saved_cnt [CORES];
	logic [31:0]      touch_s   [CORES];
	logic             warned_f  [CORES];

	verdict_t due_verdicts[$];
	int       mismatches = 0;
	int       idle_pct   = 0;
	int       stall_pct  = 0;

	buddy_core_lockup_watchdog_top #(
		.NUM_CORES (CORES),
		.COUNT_BITS(32)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Stall the result side at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare every delivered result with the oldest pending verdict.
	always @(posedge clk) begin
		verdict_t exp_v;
		verdict_t got_v;
		if (m_tvalid === 1'b1 && m_tready) begin
			got_v = verdict_t'(m_tdata[4:0]);
			if (due_verdicts.size() == 0) begin
				$display("%0t: result with no request pending, expected none, actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				exp_v = due_verdicts.pop_front();
				if (got_v.found !== exp_v.found) begin
					$display("%0t: lockup_found expected %0d actual %0d",
						$time, exp_v.found, got_v.found);
					mismatches++;
				end
				if (got_v.core !== exp_v.core) begin
					$display("%0t: lockup_core expected %0d actual %0d",
						$time, exp_v.core, got_v.core);
					mismatches++;
				end
				if (got_v.panic !== exp_v.panic) begin
					$display("%0t: lockup_panic expected %0d actual %0d",
						$time, exp_v.panic, got_v.panic);
					mismatches++;
				end
				if (m_tdata[7:5] !== 3'b000) begin
					$display("%0t: pad bits expected 0 actual %b", $time, m_tdata[7:5]);
					mismatches++;
				end
			end
		end
	end

	// Advance the watchdog state by one accepted request and return its verdict.
	function automatic verdict_t judge_event(logic [1:0] rt, logic [2:0] core,
			logic [31:0] now);
		verdict_t    v;
		logic [31:0] opp_eff;
		logic [31:0] thresh;
		logic [31:0] gap;
		int          nx;
		v = '0;
		case (rt)
			REQ_ENABLE: begin
				live_mask[core] = 1'b1;
				touch_s[core]   = now;
			end
			REQ_DISABLE: begin
				live_mask[core] = 1'b0;
			end
			REQ_TICK: begin
				if (wd_on && live_mask[core]) begin
					// a zero opportunity count behaves as one everywhere
					opp_eff = (opp_n == 8'd0) ? 32'd1 : {24'd0, opp_n};
					thresh  = {24'd0, samp_s} * opp_eff;
					tick_cnt[core] = tick_cnt[core] + 32'd1;
					if (tick_cnt[core] % opp_eff == 0) begin
						// nearest enabled neighbor in wrapping order, never the ticker
						nx = -1;
						for (int k = CORES - 1; k >= 1; k--) begin
							if (live_mask[(core + k) % CORES])
								nx = (core + k) % CORES;
						end
						if (nx >= 0) begin
							gap = now - touch_s[nx];
							// stuck count plus a strictly positive signed gap at threshold
							if (saved_cnt[nx] == tick_cnt[nx] && gap != 32'd0 && !gap[31]
									&& gap >= thresh) begin
								if (!warned_f[nx]) begin
									warned_f[nx] = 1'b1;
									v.found = 1'b1;
									v.core  = 3'(nx);
									v.panic = panic_on;
								end
							end else begin
								saved_cnt[nx] = tick_cnt[nx];
								warned_f[nx]  = 1'b0;
							end
						end
					end
					touch_s[core] = now;
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// Offer one request, hold it until taken, then record its verdict.
	task automatic send_req(input logic [1:0] rt, input logic [2:0] core,
			input logic [31:0] now);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, now, core, rt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		due_verdicts.push_back(judge_event(rt, core, now));
	endtask

	// Drop the request line and hold until every pending result is back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_verdicts.size() != 0) @(posedge clk);
	endtask

	// Write one register once the block has gone idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_WD_ENABLE: wd_on    = val[0];
			REG_SAMPLING:  samp_s   = val;
			REG_OPP_COUNT: opp_n    = val;
			REG_PANIC:     panic_on = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Out of reset the watchdog is off: ticks do nothing, enable and disable still act.
	task automatic test_reset_state();
		send_req(REQ_TICK, 3'd0, 32'd0);
		send_req(REQ_ENABLE, 3'd0, 32'd0);
		send_req(REQ_TICK, 3'd0, 32'hFFFF_FFFF);
		send_req(REQ_UNUSED, 3'd7, 32'hFFFF_FFFF);
		send_req(REQ_DISABLE, 3'd0, 32'd1);
	endtask

	// Walk through report, silence, recovery, wrapped gaps and the zero settings.
	task automatic test_lockup_rules();
		// enable bit set from a value with extra high bits
		write_reg(REG_WD_ENABLE, 8'hFF);
		write_reg(REG_SAMPLING, 8'd1);
		write_reg(REG_OPP_COUNT, 8'd1);
		write_reg(REG_PANIC, 8'd0);
		send_req(REQ_ENABLE, 3'd0, 32'd0);
		send_req(REQ_ENABLE, 3'd7, 32'd0);
		send_req(REQ_TICK, 3'd0, 32'd5);          // core 7 silent: report
		send_req(REQ_TICK, 3'd0, 32'd6);          // still silent: no repeat
		send_req(REQ_TICK, 3'd7, 32'd7);          // core 7 alive again
		send_req(REQ_TICK, 3'd0, 32'd8);          // recovery clears the warning
		send_req(REQ_TICK, 3'd0, 32'h8000_0008);  // gap negative once wrapped
		send_req(REQ_TICK, 3'd0, 32'd7);          // zero gap
		send_req(REQ_TICK, 3'd0, 32'd20);         // report again
		send_req(REQ_TICK, 3'd3, 32'd21);         // tick from a disabled core
		// zero threshold, panic severity
		write_reg(REG_SAMPLING, 8'd0);
		write_reg(REG_PANIC, 8'd1);
		send_req(REQ_TICK, 3'd7, 32'd30);
		send_req(REQ_TICK, 3'd7, 32'd31);
		// zero opportunity count behaves as one
		write_reg(REG_OPP_COUNT, 8'd0);
		send_req(REQ_TICK, 3'd0, 32'd40);
		send_req(REQ_TICK, 3'd0, 32'd41);
		// checks skipped while the count is not a multiple
		write_reg(REG_OPP_COUNT, 8'd2);
		send_req(REQ_TICK, 3'd0, 32'd60);
		// only one core left enabled: no neighbor to check
		send_req(REQ_DISABLE, 3'd7, 32'd61);
		send_req(REQ_TICK, 3'd0, 32'hFFFF_FFFF);
		// panic cleared by a value whose low bit is zero; dead index ignored
		write_reg(REG_PANIC, 8'hFE);
		write_reg(REG_NONE, 8'hFF);
		send_req(REQ_DISABLE, 3'd0, 32'd0);
	endtask

	// Random traffic around a pool of active cores, one of them mostly silent.
	task automatic test_random_traffic(input int n, input logic wd, input logic [7:0] samp,
			input logic [7:0] opp, input logic pan, input int idle, input int stall,
			input int pool_n, input logic pause_midway);
		int          base;
		int          stuck;
		int          pick;
		int          r;
		int          step_max;
		logic [31:0] wall;
		write_reg(REG_WD_ENABLE, {7'd0, wd});
		write_reg(REG_SAMPLING, samp);
		write_reg(REG_OPP_COUNT, opp);
		write_reg(REG_PANIC, {7'd0, pan});
		idle_pct  = idle;
		stall_pct = stall;
		base      = $urandom_range(CORES - 1);
		wall      = $urandom();
		stuck     = 0;
		// time moves about one tick period per request on average
		step_max  = 2 * ((samp == 8'd0) ? 1 : samp);
		for (int i = 0; i < pool_n; i++)
			send_req(REQ_ENABLE, 3'((base + i) % CORES), wall);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				stuck = $urandom_range(pool_n - 1);
			// hold the sender until the block has answered everything
			if (pause_midway && i == n / 2)
				wait_idle();
			// rare large jumps make the wrapped gap go negative
			if ($urandom_range(49) == 0)
				wall = wall + $urandom();
			else
				wall = wall + $urandom_range(step_max);
			r = $urandom_range(99);
			if (r < 72) begin
				pick = $urandom_range(pool_n - 1);
				if (pick == stuck && $urandom_range(9) != 0)
					pick = (pick + 1) % pool_n;
				send_req(REQ_TICK, 3'((base + pick) % CORES), wall);
			end else if (r < 80) begin
				if ($urandom_range(1) == 0)
					send_req(REQ_ENABLE, 3'((base + $urandom_range(pool_n - 1)) % CORES), wall);
				else
					send_req(REQ_ENABLE, 3'($urandom_range(CORES - 1)), wall);
			end else if (r < 86) begin
				send_req(REQ_DISABLE, 3'($urandom_range(CORES - 1)), wall);
			end else if (r < 95) begin
				send_req(REQ_TICK, 3'($urandom_range(CORES - 1)), wall);
			end else begin
				send_req(REQ_UNUSED, 3'($urandom_range(CORES - 1)), $urandom());
			end
		end
	endtask

	initial begin
		wd_on     = 1'b0;
		samp_s    = 8'd1;
		opp_n     = 8'd1;
		panic_on  = 1'b0;
		live_mask = '0;
		for (int c = 0; c < CORES; c++) begin
			tick_cnt[c]  = '0;
			saved_cnt[c] = '0;
			touch_s[c]   = '0;
			warned_f[c]  = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_lockup_rules();
		// no idling, tightest threshold
		test_random_traffic(220, 1'b1, 8'd1, 8'd1, 1'b0, 0, 0, 4, 1'b0);
		// sparse requests, with a full drain halfway
		test_random_traffic(220, 1'b1, 8'd3, 8'd2, 1'b1, 78, 0, 3, 1'b1);
		// heavy result back-pressure, long tick period
		test_random_traffic(220, 1'b1, 8'd255, 8'd1, 1'b0, 0, 78, 5, 1'b0);
		// watchdog off: ticks fall through
		test_random_traffic(100, 1'b0, 8'd0, 8'd0, 1'b1, 30, 30, 4, 1'b0);
		// zero settings with the watchdog on
		test_random_traffic(150, 1'b1, 8'd0, 8'd0, 1'b1, 30, 30, 4, 1'b0);
		// largest factors, two busy cores so the count reaches the opportunity
		test_random_traffic(450, 1'b1, 8'd255, 8'd255, 1'b1, 30, 30, 2, 1'b0);

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_verdicts.size() == 0)
			$display("buddy_core_lockup_watchdog_top: match");
		else
			$display("buddy_core_lockup_watchdog_top: mismatch");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#10_000_000;
		$display("buddy_core_lockup_watchdog_top: mismatch");
		$finish;
	end

endmodule
